>>> rtl/tga_pkg.sv
// Shared types and constants for the TGA pixel unpacker.
package tga_pkg;
  localparam int unsigned HdrLen = 18;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    ST_PIXEL = 2'd0,
    ST_TOP_RIGHT = 2'd1,
    ST_BAD_DEPTH = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic file_start;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] pixel_color;
    logic [15:0] dest_x;
    logic [15:0] dest_y;
    logic [1:0] status;
    logic last_pixel;
  } result_t;

  typedef struct packed {
    logic [23:0] accum;
    logic [7:0] last_byte;
    logic is32;
    logic [15:0] col;
    logic [15:0] row;
    logic [15:0] width;
    logic [15:0] height;
    logic rtl_dir;
    logic ttb_dir;
    logic is_status;
    logic [1:0] status;
  } job_t;
endpackage

>>> rtl/tga_stream_if.sv
// Valid/ready channel interface with a generic payload.
interface tga_stream_if #(
  parameter type payload_t = logic
);
  logic valid;
  logic ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/tga_front.sv
// Front end: header parse, skip counting and pixel byte gathering.
module tga_front (
  input logic clk,
  input logic rst,
  input logic in_valid,
  output logic in_ready,
  input logic [7:0] data_byte,
  input logic file_start,
  output logic job_valid,
  input logic job_ready,
  output tga_pkg::job_t job
);
  import tga_pkg::*;

  typedef enum logic [1:0] {PH_HEADER, PH_SKIP, PH_PIXELS, PH_DONE} phase_t;

  phase_t phase;
  logic [4:0] header_index;
  logic [7:0] id_length, cmap_entry_bits, pixel_bits, descriptor_bits;
  logic [15:0] cmap_entries, img_width, img_height, src_col, src_row;
  logic [21:0] skip_remaining;
  logic [1:0] byte_in_pixel;
  logic [23:0] pixel_accum;
  logic [23:0] cmap_prod;

  logic fire;
  phase_t ph;
  logic [4:0] hi;
  logic [7:0] pb_e, db_e, idl_e, ceb_e;
  logic [15:0] ce_e, w_e, h_e, col_e, row_e;
  logic [1:0] bip_e;
  logic [23:0] acc_e;
  logic last_col, final_px, is32;

  assign in_ready = job_ready;
  assign fire = in_valid && in_ready;

  always_comb begin
    ph = file_start ? PH_HEADER : phase;
    hi = file_start ? 5'd0 : header_index;
    idl_e = file_start ? 8'd0 : id_length;
    ce_e = file_start ? 16'd0 : cmap_entries;
    ceb_e = file_start ? 8'd0 : cmap_entry_bits;
    w_e = file_start ? 16'd0 : img_width;
    h_e = file_start ? 16'd0 : img_height;
    pb_e = file_start ? 8'd0 : pixel_bits;
    db_e = file_start ? 8'd0 : descriptor_bits;
    bip_e = file_start ? 2'd0 : byte_in_pixel;
    acc_e = file_start ? 24'd0 : pixel_accum;
    col_e = file_start ? 16'd0 : src_col;
    row_e = file_start ? 16'd0 : src_row;
    unique case (hi)
      5'd0: idl_e = data_byte;
      5'd5: ce_e[7:0] = data_byte;
      5'd6: ce_e[15:8] = data_byte;
      5'd7: ceb_e = data_byte;
      5'd12: w_e[7:0] = data_byte;
      5'd13: w_e[15:8] = data_byte;
      5'd14: h_e[7:0] = data_byte;
      5'd15: h_e[15:8] = data_byte;
      5'd16: pb_e = data_byte;
      5'd17: db_e = data_byte;
      default: ;
    endcase
    if (ph != PH_HEADER) begin
      idl_e = id_length; ce_e = cmap_entries; ceb_e = cmap_entry_bits;
      w_e = img_width; h_e = img_height; pb_e = pixel_bits; db_e = descriptor_bits;
    end
    is32 = (pixel_bits == 8'd32);
    last_col = (col_e == img_width - 16'd1);
    final_px = last_col && (row_e == img_height - 16'd1);
  end

  always_comb begin
    job = '0;
    job.accum = acc_e;
    job.last_byte = data_byte;
    job.is32 = is32;
    job.col = col_e;
    job.row = row_e;
    job.width = img_width;
    job.height = img_height;
    job.rtl_dir = descriptor_bits[4];
    job.ttb_dir = descriptor_bits[5];
    job_valid = 1'b0;
    if (in_valid) begin
      if (ph == PH_HEADER && hi == 5'(HdrLen - 1)) begin
        if (db_e[5:4] == 2'b11 || (pb_e != 8'd24 && pb_e != 8'd32)) begin
          job_valid = 1'b1;
          job.is_status = 1'b1;
          job.status = (pb_e != 8'd24 && pb_e != 8'd32) ? ST_BAD_DEPTH : ST_TOP_RIGHT;
        end
      end else if (ph == PH_PIXELS && bip_e == (is32 ? 2'd3 : 2'd2)) begin
        job_valid = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER;
      header_index <= '0;
      id_length <= '0; cmap_entries <= '0; cmap_entry_bits <= '0;
      img_width <= '0; img_height <= '0; pixel_bits <= '0; descriptor_bits <= '0;
      skip_remaining <= '0; byte_in_pixel <= '0; pixel_accum <= '0;
      src_col <= '0; src_row <= '0; cmap_prod <= '0;
    end else if (fire) begin
      id_length <= idl_e; cmap_entries <= ce_e; cmap_entry_bits <= ceb_e;
      img_width <= w_e; img_height <= h_e; pixel_bits <= pb_e;
      descriptor_bits <= db_e;
      header_index <= hi; byte_in_pixel <= bip_e; pixel_accum <= acc_e;
      src_col <= col_e; src_row <= row_e;
      if (file_start) skip_remaining <= '0;
      unique case (ph)
        PH_HEADER: begin
          header_index <= hi + 5'd1;
          if (hi == 5'd8) cmap_prod <= 24'(ce_e) * 24'(ceb_e);
          if (hi == 5'(HdrLen - 1)) begin
            if (job_valid) begin
              phase <= PH_DONE;
            end else if ((22'(idl_e) + 22'(cmap_prod >> 3)) != 22'd0) begin
              skip_remaining <= 22'(idl_e) + 22'(cmap_prod >> 3);
              phase <= PH_SKIP;
            end else begin
              phase <= (w_e == 16'd0 || h_e == 16'd0) ? PH_DONE : PH_PIXELS;
            end
          end else begin
            phase <= PH_HEADER;
          end
        end
        PH_SKIP: begin
          skip_remaining <= skip_remaining - 22'd1;
          phase <= (skip_remaining == 22'd1) ?
            ((img_width == 16'd0 || img_height == 16'd0) ? PH_DONE : PH_PIXELS) : PH_SKIP;
        end
        PH_PIXELS: begin
          phase <= PH_PIXELS;
          if (job_valid) begin
            byte_in_pixel <= '0;
            pixel_accum <= '0;
            if (final_px) phase <= PH_DONE;
            else if (last_col) begin
              src_col <= '0; src_row <= row_e + 16'd1;
            end else src_col <= col_e + 16'd1;
          end else begin
            byte_in_pixel <= bip_e + 2'd1;
            pixel_accum <= acc_e | (24'(data_byte) << {bip_e, 3'b000});
          end
        end
        default: phase <= PH_DONE;
      endcase
    end
  end
endmodule

>>> rtl/tga_queue.sv
// Short FIFO between the front end and the back end.
module tga_queue #(
  parameter int unsigned Depth = tga_pkg::QueueDepth
) (
  input logic clk,
  input logic rst,
  input logic wr_valid,
  output logic wr_ready,
  input tga_pkg::job_t wr_data,
  output logic rd_valid,
  input logic rd_ready,
  output tga_pkg::job_t rd_data
);
  import tga_pkg::*;
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

  job_t mem [Depth];
  logic [Aw-1:0] wptr, rptr;
  logic [Aw:0] count;
  logic do_wr, do_rd;

  assign wr_ready = (count != (Aw+1)'(Depth));
  assign rd_valid = (count != '0);
  assign rd_data = mem[rptr];
  assign do_wr = wr_valid && wr_ready;
  assign do_rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) mem[wptr] <= wr_data;
    if (rst) begin
      wptr <= '0; rptr <= '0; count <= '0;
    end else begin
      if (do_wr) wptr <= (wptr == Aw'(Depth - 1)) ? '0 : wptr + Aw'(1);
      if (do_rd) rptr <= (rptr == Aw'(Depth - 1)) ? '0 : rptr + Aw'(1);
      count <= count + (Aw+1)'(do_wr) - (Aw+1)'(do_rd);
    end
  end
endmodule

>>> rtl/tga_back.sv
// Back end: pixel packing, coordinate mapping, status beats and output register.
module tga_back (
  input logic clk,
  input logic rst,
  input logic job_valid,
  output logic job_ready,
  input tga_pkg::job_t job,
  output logic res_valid,
  input logic res_ready,
  output tga_pkg::result_t res
);
  import tga_pkg::*;
  result_t r;

  assign job_ready = !res_valid || res_ready;

  always_comb begin
    r = '0;
    if (job.is_status) begin
      r.status = job.status;
      r.last_pixel = 1'b1;
    end else begin
      r.pixel_color = job.is32 ? {job.accum, job.last_byte}
                               : {job.last_byte, job.accum[15:0], 8'd0};
      r.dest_x = job.rtl_dir ? job.width - 16'd1 - job.col : job.col;
      r.dest_y = job.ttb_dir ? job.height - 16'd1 - job.row : job.row;
      r.status = ST_PIXEL;
      r.last_pixel = (job.col == job.width - 16'd1) && (job.row == job.height - 16'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (job_valid && job_ready) res <= r;
    if (rst) res_valid <= 1'b0;
    else if (job_ready) res_valid <= job_valid;
  end
endmodule

>>> rtl/tga_pixel_unpack_reorient.sv
// Top level of the TGA truecolor pixel unpacker and reorienter.
//   channel | dir | payload
//   in      | in  | data_byte, file_start
//   out     | out | pixel_color, dest_x, dest_y, status, last_pixel
// One byte is accepted per cycle while the queue has room; results are registered.
// Rate is set by the front-end parser, which updates its counters once per byte.
// Reset is synchronous and clears all control state.
// A stalled output fills the two-entry queue, then holds the input.
module tga_pixel_unpack_reorient #(
  parameter int unsigned QueueDepth = tga_pkg::QueueDepth
) (
  input logic clk,
  input logic rst,
  tga_stream_if.sink in,
  tga_stream_if.source out
);
  import tga_pkg::*;

  logic fq_valid, fq_ready, qb_valid, qb_ready;
  job_t fq_job, qb_job;
  result_t res;

  tga_front u_front (
    .clk, .rst,
    .in_valid(in.valid), .in_ready(in.ready),
    .data_byte(in.payload.data_byte), .file_start(in.payload.file_start),
    .job_valid(fq_valid), .job_ready(fq_ready), .job(fq_job)
  );

  tga_queue #(.Depth(QueueDepth)) u_queue (
    .clk, .rst,
    .wr_valid(fq_valid && in.valid), .wr_ready(fq_ready), .wr_data(fq_job),
    .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_job)
  );

  tga_back u_back (
    .clk, .rst,
    .job_valid(qb_valid), .job_ready(qb_ready), .job(qb_job),
    .res_valid(out.valid), .res_ready(out.ready), .res
  );

  assign out.payload.pixel_color = res.pixel_color;
  assign out.payload.dest_x = res.dest_x;
  assign out.payload.dest_y = res.dest_y;
  assign out.payload.status = res.status;
  assign out.payload.last_pixel = res.last_pixel;
endmodule

>>> dv/tga_unpack_checker.sv
// Scoreboard that predicts and checks every pixel and status beat of the unpacker.
module tga_unpack_checker (
  input logic clk,
  input logic rst,
  tga_stream_if mon_in,
  tga_stream_if mon_out,
  output int fail_count,
  output int pending
);
  import tga_pkg::*;

  typedef enum logic [1:0] {
    PARSE_HDR,
    PARSE_SKIP,
    PARSE_PIX,
    PARSE_DONE
  } parse_t;

  parse_t parse;
  logic [4:0] hdr_idx;
  logic [7:0] id_len;
  logic [15:0] cmap_cnt;
  logic [7:0] cmap_bits;
  logic [15:0] width;
  logic [15:0] height;
  logic [7:0] depth;
  logic [7:0] descr;
  logic [21:0] skip_left;
  logic [1:0] pix_byte;
  logic [23:0] accum;
  logic [15:0] col;
  logic [15:0] row;
  result_t expected_beats[$];

  function automatic result_t status_beat(input status_t code);
    result_t r;
    r = '0;
    r.status = code;
    r.last_pixel = 1'b1;
    return r;
  endfunction

  task automatic clear_parser();
    parse = PARSE_HDR;
    hdr_idx = '0;
    id_len = '0;
    cmap_cnt = '0;
    cmap_bits = '0;
    width = '0;
    height = '0;
    depth = '0;
    descr = '0;
    skip_left = '0;
    pix_byte = '0;
    accum = '0;
    col = '0;
    row = '0;
  endtask

  task automatic enter_image();
    parse = (width == 0 || height == 0) ? PARSE_DONE : PARSE_PIX;
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic start);
    logic [31:0] color;
    logic [31:0] skip_sum;
    logic [1:0] last_idx;
    logic final_px;
    result_t r;
    if (start) clear_parser();
    case (parse)
      PARSE_HDR: begin
        case (hdr_idx)
          5'd0: id_len = b;
          5'd5: cmap_cnt[7:0] = b;
          5'd6: cmap_cnt[15:8] = b;
          5'd7: cmap_bits = b;
          5'd12: width[7:0] = b;
          5'd13: width[15:8] = b;
          5'd14: height[7:0] = b;
          5'd15: height[15:8] = b;
          5'd16: depth = b;
          5'd17: descr = b;
          default: ;
        endcase
        hdr_idx = hdr_idx + 5'd1;
        if (hdr_idx >= HdrLen) begin
          if (depth != 8'd24 && depth != 8'd32) begin
            expected_beats = {expected_beats, status_beat(ST_BAD_DEPTH)};
            parse = PARSE_DONE;
          end else if (descr[5:4] == 2'b11) begin
            expected_beats = {expected_beats, status_beat(ST_TOP_RIGHT)};
            parse = PARSE_DONE;
          end else begin
            skip_sum = 32'(id_len) + (32'(cmap_cnt) * 32'(cmap_bits)) / 32'd8;
            skip_left = skip_sum[21:0];
            if (skip_left != 0) parse = PARSE_SKIP;
            else enter_image();
          end
        end
      end
      PARSE_SKIP: begin
        skip_left = skip_left - 22'd1;
        if (skip_left == 0) enter_image();
      end
      PARSE_PIX: begin
        last_idx = (depth == 8'd32) ? 2'd3 : 2'd2;
        if (pix_byte < last_idx) begin
          accum = accum | (24'(b) << (8 * pix_byte));
          pix_byte = pix_byte + 2'd1;
        end else begin
          if (last_idx == 2'd2) color = {b, accum[15:0], 8'h00};
          else color = {accum, b};
          final_px = (col == width - 16'd1) && (row == height - 16'd1);
          r.pixel_color = color;
          r.dest_x = descr[4] ? (width - 16'd1 - col) : col;
          r.dest_y = descr[5] ? (height - 16'd1 - row) : row;
          r.status = ST_PIXEL;
          r.last_pixel = final_px;
          expected_beats = {expected_beats, r};
          pix_byte = '0;
          accum = '0;
          if (final_px) begin
            parse = PARSE_DONE;
          end else if (col == width - 16'd1) begin
            col = '0;
            row = row + 16'd1;
          end else begin
            col = col + 16'd1;
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t exp_beat;
    if (rst) begin
      clear_parser();
      expected_beats.delete();
      fail_count <= 0;
    end else begin
      if (mon_in.valid && mon_in.ready)
        decode_byte(mon_in.payload.data_byte, mon_in.payload.file_start);
      if (mon_out.valid && mon_out.ready) begin
        got = mon_out.payload;
        if (expected_beats.size() == 0) begin
          $display("%0t: unexpected beat %h, expected none", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          exp_beat = expected_beats.pop_front();
          if (got !== exp_beat) begin
            $display("%0t: mismatch expected color=%h x=%0d y=%0d st=%0d last=%0b",
                     $time, exp_beat.pixel_color, exp_beat.dest_x, exp_beat.dest_y,
                     exp_beat.status, exp_beat.last_pixel);
            $display("%0t:          actual   color=%h x=%0d y=%0d st=%0d last=%0b",
                     $time, got.pixel_color, got.dest_x, got.dest_y, got.status,
                     got.last_pixel);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending <= expected_beats.size();
  end
endmodule

>>> dv/tb_top.sv
// Stimulus and verdict for the TGA pixel unpacker testbench.
module tb_top;
  import tga_pkg::*;

  logic clk;
  logic rst;
  int fail_count;
  int pending;
  int cycles = 0;
  int bytes_sent;
  logic no_idle;

  tga_stream_if #(.payload_t(in_beat_t)) in_ch ();
  tga_stream_if #(.payload_t(result_t)) out_ch ();

  tga_pixel_unpack_reorient u_dut (
    .clk(clk),
    .rst(rst),
    .in(in_ch),
    .out(out_ch)
  );

  tga_unpack_checker u_checker (
    .clk(clk),
    .rst(rst),
    .mon_in(in_ch),
    .mon_out(out_ch),
    .fail_count(fail_count),
    .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else out_ch.ready <= (pick_gap() == 0);
  end

  task automatic send_byte(input logic [7:0] b, input logic start);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.payload <= '{data_byte: b, file_start: start};
    forever begin
      @(posedge clk);
      if (in_ch.ready) break;
    end
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_file(input logic [15:0] w, input logic [15:0] h, input logic [7:0] bpp,
                           input logic [7:0] descr, input logic [7:0] id_len,
                           input logic [15:0] cmap_n, input logic [7:0] cmap_b,
                           input int cut_at, input int tail);
    int body;
    int skip;
    int sent;
    logic [7:0] hdr[18];
    for (int i = 0; i < 18; i++) hdr[i] = 8'($urandom_range(0, 255));
    hdr[0] = id_len;
    hdr[5] = cmap_n[7:0];
    hdr[6] = cmap_n[15:8];
    hdr[7] = cmap_b;
    hdr[12] = w[7:0];
    hdr[13] = w[15:8];
    hdr[14] = h[7:0];
    hdr[15] = h[15:8];
    hdr[16] = bpp;
    hdr[17] = descr;
    skip = int'(id_len) + (int'(cmap_n) * int'(cmap_b)) / 8;
    body = (bpp == 8'd24 || bpp == 8'd32) ? int'(w) * int'(h) * int'(bpp) / 8 : 0;
    sent = 0;
    for (int i = 0; i < 18 + skip + body + tail; i++) begin
      if (cut_at >= 0 && sent >= cut_at) break;
      if (i < 18) send_byte(hdr[i], i == 0);
      else send_byte(($urandom_range(0, 3) == 0) ?
                       (($urandom_range(0, 1) != 0) ? 8'hff : 8'h00)
                     : 8'($urandom_range(0, 255)), 1'b0);
      sent++;
    end
  endtask

  initial begin
    int dirs;
    rst = 1'b1;
    bytes_sent = 0;
    no_idle = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed files: orientations, depths, empty images, skips and restarts.
    send_file(16'd3, 16'd2, 8'd32, 8'h00, 8'd0, 16'd0, 8'd0, -1, 2);
    send_file(16'd3, 16'd2, 8'd24, 8'h20, 8'd2, 16'd0, 8'd0, -1, 0);
    send_file(16'd2, 16'd3, 8'd32, 8'h10, 8'd0, 16'd4, 8'd24, -1, 3);
    send_file(16'd2, 16'd2, 8'd24, 8'h30, 8'd0, 16'd0, 8'd0, -1, 4);
    send_file(16'd2, 16'd2, 8'd16, 8'h30, 8'd0, 16'd0, 8'd0, -1, 4);
    send_file(16'd1, 16'd1, 8'd0, 8'h00, 8'd0, 16'd0, 8'd0, -1, 0);
    send_file(16'd1, 16'd1, 8'd255, 8'h00, 8'd0, 16'd0, 8'd0, -1, 0);
    send_file(16'd0, 16'd5, 8'd24, 8'h00, 8'd0, 16'd0, 8'd0, -1, 6);
    send_file(16'd5, 16'd0, 8'd32, 8'h00, 8'd1, 16'd0, 8'd0, -1, 0);
    send_file(16'd1, 16'd1, 8'd24, 8'h00, 8'd255, 16'h0103, 8'd1, -1, 0);
    send_file(16'd4, 16'd4, 8'd32, 8'h00, 8'd0, 16'd0, 8'd0, 30, 0);
    send_file(16'd1, 16'd1, 8'd24, 8'h00, 8'd0, 16'd0, 8'd0, 10, 0);
    send_file(16'd1, 16'd2, 8'd32, 8'hcf, 8'd0, 16'd3, 8'd5, -1, 1);
    send_file(16'd2, 16'd1, 8'd24, 8'hdf, 8'd0, 16'd0, 8'd0, -1, 0);

    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);

    while (bytes_sent < 850) begin
      logic [7:0] bpp;
      logic [7:0] descr;
      dirs = $urandom_range(0, 99);
      no_idle = ($urandom_range(0, 5) == 0);
      bpp = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                         : (($urandom_range(0, 1) != 0) ? 8'd32 : 8'd24);
      descr = 8'($urandom_range(0, 255));
      if (dirs < 85 && descr[5:4] == 2'b11) descr[5] = 1'b0;
      send_file(16'($urandom_range(dirs < 5 ? 0 : 1, 4)),
                16'($urandom_range(dirs > 95 ? 0 : 1, 4)),
                bpp, descr,
                ($urandom_range(0, 1) != 0) ? 8'd0 : 8'($urandom_range(0, 6)),
                ($urandom_range(0, 1) != 0) ? 16'd0 : 16'($urandom_range(0, 3)),
                8'($urandom_range(0, 32)),
                ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 40)) : -1,
                int'($urandom_range(0, 3)));
    end
    no_idle = 1'b0;
    in_ch.valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end
endmodule
